// File: hw/rtl/bior_pkg.sv
// Shared types and constants of the bus I/O register bridge.
`timescale 1ns / 1ps
`default_nettype none

package bior_pkg;

	// Register map behind the address pointer.
	localparam logic [7:0] REG_SELECT  = 8'd0;
	localparam logic [7:0] REG_STATUS  = 8'd4;
	localparam logic [7:0] REG_DATA    = 8'd5;
	localparam logic [7:0] REG_MASK    = 8'd14;
	localparam logic [7:0] REG_PENDING = 8'd15;

	localparam logic [2:0] SEL_NONE = 3'd7;

	// Request kinds.
	localparam logic KIND_HOST = 1'b0;
	localparam logic KIND_RX   = 1'b1;

	// Bit of the interrupt mask that enables the receive interrupt.
	localparam int IRQ_RX_BIT = 0;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} bior_state_t;

	// Control from the top level to the ring memory.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ring_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/bus_io_register_bridge_core.sv
// Top level of the bus I/O register bridge.
`timescale 1ns / 1ps
`default_nettype none

// Host bus slave with an indirect address pointer and a receive ring of
// RING_DEPTH bytes. Each request is either a host access (pointer or register
// read/write) or one received serial byte, and gives exactly one response.
// Every response is registered and shown in the cycle after its request,
// but a receive-data read first passes the registered ring read and ST_READ.
// One request is in work at a time; a new request is taken while the
// previous response is being taken. After reset the ring is cleared one entry
// per cycle, and no request is taken until every entry is cleared.
module bus_io_register_bridge_core
	import bior_pkg::*;
#(
	parameter int RING_DEPTH = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       kind,
	input  wire logic       pointer_phase,
	input  wire logic       is_read,
	input  wire logic [7:0] write_data,
	input  wire logic [7:0] rx_byte,
	input  wire logic       tx_empty,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] read_data,
	output logic            irq_out,
	output logic      [2:0] chip_select,
	output logic            tx_valid,
	output logic      [7:0] tx_byte
);

	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	bior_state_t   state_q, state_next;
	ring_ctl_t     ring_ctl;
	logic          ring_clearing;
	logic [7:0]    ring_rd_data;

	logic [7:0]    reg_pointer_q;
	logic [2:0]    select_q;
	logic [7:0]    irq_mask_q;
	logic          rx_pending_q;
	logic          underflow_q;
	logic          irq_q;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [7:0]    last_data_q;
	logic          out_valid_q;
	logic          tx_valid_q;
	logic [7:0]    tx_byte_q;

	logic          accept;
	logic          is_host;
	logic          reg_access;
	logic          data_read;
	logic          ring_empty;
	logic [AW-1:0] wr_ptr_next;
	logic [AW-1:0] rd_ptr_next;
	logic [AW-1:0] rd_ptr_after;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		ring_next = (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign accept      = in_valid & in_ready;
	assign is_host     = (kind == KIND_HOST);
	assign reg_access  = is_host & ~pointer_phase;
	assign data_read   = reg_access & is_read & (reg_pointer_q == REG_DATA);
	assign ring_empty  = (wr_ptr_q == rd_ptr_q);
	assign wr_ptr_next = ring_next(wr_ptr_q);
	assign rd_ptr_next = ring_next(rd_ptr_q);
	assign rd_ptr_after = ring_empty ? rd_ptr_q : rd_ptr_next;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && data_read) begin
					state_next = ST_READ;
				end
			end
			ST_READ: state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		ring_ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready       = ~ring_clearing & (~out_valid_q | out_ready);
				ring_ctl.wr_en = in_valid & in_ready & ~is_host;
				ring_ctl.rd_en = in_valid & in_ready & data_read;
			end
			ST_READ: begin
				in_ready = 1'b0;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			reg_pointer_q <= '0;
			select_q      <= SEL_NONE;
			irq_mask_q    <= '0;
			rx_pending_q  <= 1'b0;
			underflow_q   <= 1'b0;
			irq_q         <= 1'b0;
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			last_data_q   <= '0;
			out_valid_q   <= 1'b0;
			tx_valid_q    <= 1'b0;
			tx_byte_q     <= '0;
		end else begin
			state_q <= state_next;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_READ) begin
				last_data_q <= ring_rd_data;
				out_valid_q <= 1'b1;
			end
			if (accept) begin
				tx_valid_q <= 1'b0;
				tx_byte_q  <= '0;
				// A receive-data read shows its response once the ring has answered.
				out_valid_q <= ~data_read;
				if (!is_host) begin
					wr_ptr_q     <= wr_ptr_next;
					rx_pending_q <= 1'b1;
					if (irq_mask_q[IRQ_RX_BIT]) begin
						irq_q <= 1'b1;
					end
				end else if (pointer_phase) begin
					if (is_read) begin
						last_data_q <= reg_pointer_q;
					end else begin
						reg_pointer_q <= write_data;
					end
				end else begin
					case (reg_pointer_q)
						REG_SELECT: begin
							if (is_read) begin
								last_data_q <= {2'b00, select_q, 3'b000};
							end else begin
								select_q <= write_data[5:3];
							end
						end
						REG_STATUS: begin
							if (is_read) begin
								last_data_q <= {tx_empty, 6'b000000, underflow_q};
							end
						end
						REG_DATA: begin
							if (is_read) begin
								rd_ptr_q <= rd_ptr_after;
								if (ring_empty) begin
									underflow_q <= 1'b1;
								end
								if (wr_ptr_q == rd_ptr_after) begin
									rx_pending_q <= 1'b0;
									irq_q        <= 1'b0;
								end
							end else begin
								tx_valid_q <= 1'b1;
								tx_byte_q  <= write_data;
							end
						end
						REG_MASK: begin
							if (is_read) begin
								last_data_q <= irq_mask_q;
							end else begin
								irq_mask_q <= write_data;
							end
						end
						REG_PENDING: begin
							if (is_read) begin
								last_data_q <= {7'b0000000, rx_pending_q};
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	bior_ring #(
		.DEPTH(RING_DEPTH),
		.AW   (AW)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ring_ctl),
		.wr_addr (wr_ptr_q),
		.wr_data (rx_byte),
		.rd_addr (rd_ptr_q),
		.rd_data (ring_rd_data),
		.clearing(ring_clearing)
	);

	assign out_valid   = out_valid_q;
	assign read_data   = last_data_q;
	assign irq_out     = irq_q;
	assign chip_select = select_q;
	assign tx_valid    = tx_valid_q;
	assign tx_byte     = tx_byte_q;

endmodule

`default_nettype wire

// File: hw/rtl/bior_ring.sv
// Receive ring memory with its clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module bior_ring
	import bior_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ring_ctl_t     ctl,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data,
	output logic               clearing
);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic          clearing_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// The sweep owns the write port until every entry holds zero.
	always_comb begin
		we    = clearing_q | ctl.wr_en;
		waddr = clearing_q ? clr_addr_q : wr_addr;
		wdata = clearing_q ? 8'h00 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clearing = clearing_q;

endmodule

`default_nettype wire

// File: hw/rtl/bior_checker.sv
// Port-level assertions for the bridge, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module bior_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] read_data,
	input wire logic [2:0] chip_select,
	input wire logic       tx_valid,
	input wire logic [7:0] tx_byte
);

	// A stalled response keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(tx_byte))
		else $error("response changed while stalled");

	// A new request is taken only when the single response slot is empty or draining.
	a_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while response slot is full");

	// The chip select only moves as the result of a request.
	a_sel_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(in_valid && in_ready) |-> $stable(chip_select))
		else $error("chip select changed without a request");

	// No transmit byte is shown unless a transmit write happened.
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == 8'h00)
		else $error("transmit byte set without transmit write");

endmodule

bind bus_io_register_bridge_core bior_checker u_bior_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.read_data  (read_data),
	.chip_select(chip_select),
	.tx_valid   (tx_valid),
	.tx_byte    (tx_byte)
);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the bus I/O register bridge core.
`timescale 1ns / 1ps

module tb_top;
	import bior_pkg::*;

	localparam int RING_SLOTS    = 256;
	localparam int TOTAL_ITEMS   = 650;
	localparam int QUIET_TAIL    = 60;
	localparam int SETTLE_CYCLES = 20;
	// The stall limit leaves room for the ring clear after reset and for the idle bursts.
	localparam int STALL_LIMIT   = 2000;

	localparam logic PHASE_POINTER  = 1'b1;
	localparam logic PHASE_REGISTER = 1'b0;
	localparam logic ACC_READ       = 1'b1;
	localparam logic ACC_WRITE      = 1'b0;

	typedef struct packed {
		logic       kind;
		logic       pointer_phase;
		logic       is_read;
		logic [7:0] write_data;
		logic [7:0] rx_byte;
		logic       tx_empty;
	} bus_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
		logic [2:0] chip_select;
		logic       tx_valid;
		logic [7:0] tx_byte;
	} bus_resp_t;

	typedef struct packed {
		bus_req_t  req;
		logic      typed;
		bus_resp_t typed_resp;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       kind;
	logic       pointer_phase;
	logic       is_read;
	logic [7:0] write_data;
	logic [7:0] rx_byte;
	logic       tx_empty;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] read_data;
	logic       irq_out;
	logic [2:0] chip_select;
	logic       tx_valid;
	logic [7:0] tx_byte;

	// Mirror of the bridge state, advanced once per accepted request.
	logic [7:0] mirror_ring [RING_SLOTS] = '{default: 8'h00};
	logic [7:0] mirror_wr        = '0;
	logic [7:0] mirror_rd        = '0;
	logic [7:0] mirror_ptr       = '0;
	logic [2:0] mirror_sel       = SEL_NONE;
	logic [7:0] mirror_mask      = '0;
	logic       mirror_pending   = 1'b0;
	logic       mirror_underflow = 1'b0;
	logic       mirror_irq       = 1'b0;
	logic [7:0] mirror_last      = '0;

	stim_row_t   stim [$];
	bus_resp_t   responses_due [$];
	int unsigned accepted_cnt = 0;
	int unsigned mismatches   = 0;
	int unsigned idle_cycles  = 0;
	bit          steady_tail  = 1'b0;

	bus_io_register_bridge_core #(
		.RING_DEPTH(RING_SLOTS)
	) u_dut (
		.clk, .arst_n, .in_valid, .in_ready, .kind, .pointer_phase, .is_read,
		.write_data, .rx_byte, .tx_empty, .out_valid, .out_ready, .read_data,
		.irq_out, .chip_select, .tx_valid, .tx_byte
	);

	always #5 clk = ~clk;

	function automatic bus_resp_t predict_bridge(bus_req_t rq);
		bus_resp_t r;
		r.tx_valid = 1'b0;
		r.tx_byte  = 8'h00;
		if (rq.kind == KIND_RX) begin
			mirror_ring[mirror_wr] = rq.rx_byte;
			mirror_wr = mirror_wr + 8'd1;
			mirror_pending = 1'b1;
			if (mirror_mask[IRQ_RX_BIT])
				mirror_irq = 1'b1;
		end else if (rq.pointer_phase == PHASE_POINTER) begin
			if (rq.is_read == ACC_READ)
				mirror_last = mirror_ptr;
			else
				mirror_ptr = rq.write_data;
		end else begin
			case (mirror_ptr)
				REG_SELECT: begin
					if (rq.is_read == ACC_READ)
						mirror_last = {2'b00, mirror_sel, 3'b000};
					else
						mirror_sel = rq.write_data[5:3];
				end
				REG_STATUS: begin
					if (rq.is_read == ACC_READ)
						mirror_last = {rq.tx_empty, 6'b000000, mirror_underflow};
				end
				REG_DATA: begin
					if (rq.is_read == ACC_READ) begin
						mirror_last = mirror_ring[mirror_rd];
						if (mirror_wr != mirror_rd)
							mirror_rd = mirror_rd + 8'd1;
						else
							mirror_underflow = 1'b1;
						if (mirror_wr == mirror_rd) begin
							mirror_pending = 1'b0;
							mirror_irq = 1'b0;
						end
					end else begin
						r.tx_valid = 1'b1;
						r.tx_byte  = rq.write_data;
					end
				end
				REG_MASK: begin
					if (rq.is_read == ACC_READ)
						mirror_last = mirror_mask;
					else
						mirror_mask = rq.write_data;
				end
				REG_PENDING: begin
					if (rq.is_read == ACC_READ)
						mirror_last = {7'b0000000, mirror_pending};
				end
				default: ;
			endcase
		end
		r.read_data   = mirror_last;
		r.irq         = mirror_irq;
		r.chip_select = mirror_sel;
		return r;
	endfunction

	function automatic bus_req_t random_request();
		bus_req_t rq;
		rq.kind          = 1'($urandom_range(0, 1));
		rq.pointer_phase = 1'($urandom_range(0, 1));
		rq.is_read       = 1'($urandom_range(0, 1));
		rq.write_data    = 8'($urandom_range(0, 255));
		rq.rx_byte       = 8'($urandom_range(0, 255));
		rq.tx_empty      = 1'($urandom_range(0, 1));
		return rq;
	endfunction

	function automatic stim_row_t dir_row(logic typed, logic k, logic pp, logic rd,
			logic [7:0] wd, logic [7:0] rxb, logic txe, logic [7:0] e_data,
			logic e_irq, logic [2:0] e_cs, logic e_txv, logic [7:0] e_txb);
		stim_row_t row;
		row.req        = {k, pp, rd, wd, rxb, txe};
		row.typed      = typed;
		row.typed_resp = {e_data, e_irq, e_cs, e_txv, e_txb};
		return row;
	endfunction

	task automatic flag_mismatch(string what, int unsigned want_v, int unsigned got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what,
				want_v, got_v);
	endtask

	// Requests and responses are both sampled here, before this edge's updates land.
	always @(posedge clk) begin
		bus_resp_t got;
		bus_resp_t want;
		bus_req_t  seen;
		if (out_valid === 1'b1 && out_ready) begin
			got = {read_data, irq_out, chip_select, tx_valid, tx_byte};
			if (responses_due.size() == 0) begin
				flag_mismatch("unrequested response, read_data", 0, 32'(got.read_data));
			end else begin
				want = responses_due.pop_front();
				if (got.read_data !== want.read_data)
					flag_mismatch("read_data", 32'(want.read_data), 32'(got.read_data));
				if (got.irq !== want.irq)
					flag_mismatch("irq_out", 32'(want.irq), 32'(got.irq));
				if (got.chip_select !== want.chip_select)
					flag_mismatch("chip_select", 32'(want.chip_select),
						32'(got.chip_select));
				if (got.tx_valid !== want.tx_valid)
					flag_mismatch("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
				if (got.tx_byte !== want.tx_byte)
					flag_mismatch("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
			end
		end
		if (in_valid && in_ready === 1'b1) begin
			seen = {kind, pointer_phase, is_read, write_data, rx_byte, tx_empty};
			want = predict_bridge(seen);
			if (stim[accepted_cnt].typed)
				want = stim[accepted_cnt].typed_resp;
			responses_due.push_back(want);
			accepted_cnt++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == STALL_LIMIT) begin
			$display("%0t: no request or response moved for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		out_ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!steady_tail && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	initial begin
		bus_req_t   rq;
		logic [7:0] target;
		logic [7:0] mapped_regs [6];
		int         pick;
		bit         overflow_done;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = KIND_HOST;
		pointer_phase = PHASE_POINTER;
		is_read       = ACC_READ;
		write_data    = 8'h00;
		rx_byte       = 8'h00;
		tx_empty      = 1'b0;
		overflow_done = 1'b0;
		mapped_regs   = '{REG_SELECT, REG_STATUS, REG_DATA, REG_DATA, REG_MASK, REG_PENDING};

		// Directed part: reset values, register map, unmapped address, underflow, interrupt.
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_POINTER, ACC_READ, 8'h00, 8'h5A, 1'b0,
			8'h00, 1'b0, SEL_NONE, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_READ, 8'h00, 8'hA5, 1'b1,
			8'h38, 1'b0, SEL_NONE, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_WRITE, 8'hD5, 8'h00, 1'b0,
			8'h38, 1'b0, 3'd2, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_WRITE, 8'h00, 8'hFF, 1'b1,
			8'h38, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_POINTER, ACC_WRITE, 8'hFF, 8'h00, 1'b0,
			8'h38, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_POINTER, ACC_READ, 8'h00, 8'h00, 1'b0,
			8'hFF, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_READ, 8'h00, 8'h00, 1'b0,
			8'hFF, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_WRITE, 8'h12, 8'h00, 1'b0,
			8'hFF, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_POINTER, ACC_WRITE, REG_STATUS, 8'h00,
			1'b0, 8'hFF, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_READ, 8'h00, 8'h00, 1'b1,
			8'h80, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_WRITE, 8'hFF, 8'h00, 1'b1,
			8'h80, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_POINTER, ACC_WRITE, REG_DATA, 8'h00,
			1'b0, 8'h80, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_READ, 8'h00, 8'h00, 1'b0,
			8'h00, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_WRITE, 8'hA5, 8'h00, 1'b0,
			8'h00, 1'b0, 3'd0, 1'b1, 8'hA5));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_POINTER, ACC_WRITE, REG_MASK, 8'h00,
			1'b0, 8'h00, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_WRITE, 8'hFF, 8'h00, 1'b0,
			8'h00, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_READ, 8'h00, 8'h00, 1'b0,
			8'hFF, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_RX, PHASE_POINTER, ACC_READ, 8'h00, 8'hFF, 1'b0,
			8'hFF, 1'b1, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_RX, PHASE_REGISTER, ACC_WRITE, 8'hFF, 8'h3C, 1'b1,
			8'hFF, 1'b1, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_POINTER, ACC_WRITE, REG_PENDING, 8'h00,
			1'b0, 8'hFF, 1'b1, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_READ, 8'h00, 8'h00, 1'b0,
			8'h01, 1'b1, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_WRITE, 8'h00, 8'h00, 1'b0,
			8'h01, 1'b1, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_POINTER, ACC_WRITE, REG_DATA, 8'h00,
			1'b0, 8'h01, 1'b1, 3'd0, 1'b0, 8'h00));
		// Draining the ring: checked against the mirror.
		stim.push_back(dir_row(1'b0, KIND_HOST, PHASE_REGISTER, ACC_READ, 8'h00, 8'h00, 1'b0,
			8'h00, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b0, KIND_HOST, PHASE_REGISTER, ACC_READ, 8'h00, 8'h00, 1'b0,
			8'h00, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_POINTER, ACC_WRITE, REG_STATUS, 8'h00,
			1'b0, 8'h3C, 1'b0, 3'd0, 1'b0, 8'h00));
		stim.push_back(dir_row(1'b1, KIND_HOST, PHASE_REGISTER, ACC_READ, 8'h00, 8'h00, 1'b0,
			8'h01, 1'b0, 3'd0, 1'b0, 8'h00));

		// Random part: mostly a pointer write followed by accesses to that register.
		while (stim.size() < TOTAL_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (!overflow_done && stim.size() >= 180) begin
				// Enough unread bytes to wrap the ring all the way around.
				repeat (RING_SLOTS) begin
					rq = random_request();
					rq.kind = KIND_RX;
					stim.push_back('{rq, 1'b0, '0});
				end
				overflow_done = 1'b1;
			end else if (pick < 20) begin
				repeat ($urandom_range(1, 6)) begin
					rq = random_request();
					rq.kind = KIND_RX;
					stim.push_back('{rq, 1'b0, '0});
				end
			end else if (pick < 85) begin
				if (pick < 75)
					target = mapped_regs[3'($urandom_range(0, 5))];
				else
					target = 8'($urandom_range(0, 255));
				rq = random_request();
				rq.kind = KIND_HOST;
				rq.pointer_phase = PHASE_POINTER;
				rq.is_read = ACC_WRITE;
				rq.write_data = target;
				stim.push_back('{rq, 1'b0, '0});
				repeat ($urandom_range(1, 5)) begin
					rq = random_request();
					rq.kind = KIND_HOST;
					rq.pointer_phase = PHASE_REGISTER;
					if (target == REG_DATA && $urandom_range(0, 2) != 0)
						rq.is_read = ACC_READ;
					stim.push_back('{rq, 1'b0, '0});
				end
			end else if (pick < 90) begin
				rq = random_request();
				rq.kind = KIND_HOST;
				rq.pointer_phase = PHASE_POINTER;
				rq.is_read = ACC_READ;
				stim.push_back('{rq, 1'b0, '0});
			end else begin
				repeat ($urandom_range(1, 3)) begin
					rq = random_request();
					stim.push_back('{rq, 1'b0, '0});
				end
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < stim.size(); i++) begin
			if (i >= stim.size() - QUIET_TAIL)
				steady_tail = 1'b1;
			if (!steady_tail && $urandom_range(0, 4) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			in_valid      <= 1'b1;
			kind          <= stim[i].req.kind;
			pointer_phase <= stim[i].req.pointer_phase;
			is_read       <= stim[i].req.is_read;
			write_data    <= stim[i].req.write_data;
			rx_byte       <= stim[i].req.rx_byte;
			tx_empty      <= stim[i].req.tx_empty;
			do @(posedge clk); while (in_ready !== 1'b1);
		end
		in_valid <= 1'b0;

		wait (responses_due.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && responses_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/bior_pkg.sv
hw/rtl/bior_ring.sv
hw/rtl/bus_io_register_bridge_core.sv
hw/rtl/bior_checker.sv
tb/tb_top.sv
